// ===== rtl/core/bvg_pkg.sv =====
// ----------------------------------------------------------------------------
// bvg_pkg
// Shared widths, register codes and unit status type for the battery gauge.
// ----------------------------------------------------------------------------
package bvg_pkg;

  localparam int TIME_BITS = 48;
  localparam int ADC_BITS  = 12;

  localparam int RATIO_W   = 8;
  localparam int MV_W      = 16;
  localparam int PCT_W     = 8;
  localparam int CFG_IDX_W = 3;

  // pin * ratio product, and the shared divider numerator width
  localparam int PROD_W    = ADC_BITS + RATIO_W;
  localparam int PCT_NUM_W = MV_W + 7;
  localparam int DIV_NW    = (PROD_W > PCT_NUM_W) ? PROD_W : PCT_NUM_W;

  localparam int TCNT_W    = $clog2(TIME_BITS);
  localparam int MCNT_W    = $clog2(RATIO_W);
  localparam int DCNT_W    = $clog2(DIV_NW);

  localparam int IN_W      = TIME_BITS + ADC_BITS;
  localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W     = 1 + 1 + MV_W + PCT_W + 1;
  localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [MV_W-1:0]  SCALE_DIVISOR = 16'd10;
  localparam logic [PCT_W-1:0] PCT_FULL      = 8'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY     = 8'd0;
  localparam logic [PCT_W-1:0] PCT_UNKNOWN   = 8'd255;
  localparam logic [PCT_NUM_W-1:0] PCT_SCALE = 23'd100;

  localparam logic [RATIO_W-1:0] RST_DIVIDER  = 8'd20;
  localparam logic [MV_W-1:0]    RST_PL_MIN   = 16'd2500;
  localparam logic [MV_W-1:0]    RST_PL_MAX   = 16'd4500;
  localparam logic [MV_W-1:0]    RST_FULL     = 16'd4200;
  localparam logic [MV_W-1:0]    RST_EMPTY    = 16'd3300;
  localparam logic [MV_W-1:0]    RST_LOW      = 16'd3500;
  localparam logic [MV_W-1:0]    RST_INTERVAL = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIVIDER  = 3'd0,
    REG_PL_MIN   = 3'd1,
    REG_PL_MAX   = 3'd2,
    REG_FULL     = 3'd3,
    REG_EMPTY    = 3'd4,
    REG_LOW      = 3'd5,
    REG_INTERVAL = 3'd6
  } cfg_reg_t;

  // status of an iterative unit: busy while shifting, done as busy drops
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== rtl/core/bvg_tcmp.sv =====
// ----------------------------------------------------------------------------
// bvg_tcmp
// Bit-serial elapsed-time check: (now - last) mod 2^TIME_BITS < interval.
// ----------------------------------------------------------------------------
module bvg_tcmp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [bvg_pkg::TIME_BITS-1:0]  now_ms,
  input  logic [bvg_pkg::TIME_BITS-1:0]  last_ms,
  input  logic [bvg_pkg::MV_W-1:0]       interval_ms,
  output bvg_pkg::unit_stat_t            stat,
  output logic                           less
);

  logic [bvg_pkg::TIME_BITS-1:0] now_sr;
  logic [bvg_pkg::TIME_BITS-1:0] last_sr;
  logic [bvg_pkg::TIME_BITS-1:0] ivl_sr;
  logic [bvg_pkg::TCNT_W-1:0]    cnt;
  logic                          borrow;
  logic                          busy;
  logic                          done;
  logic                          d_bit;
  logic                          borrow_next;
  logic                          less_next;

  // one difference bit per cycle, LSB first; compare runs on the same bit
  assign d_bit       = now_sr[0] ^ last_sr[0] ^ borrow;
  assign borrow_next = (~now_sr[0] & last_sr[0]) | (~(now_sr[0] ^ last_sr[0]) & borrow);
  assign less_next   = (~d_bit & ivl_sr[0]) | (~(d_bit ^ ivl_sr[0]) & less);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        now_sr  <= now_ms;
        last_sr <= last_ms;
        ivl_sr  <= bvg_pkg::TIME_BITS'(interval_ms);
        borrow  <= 1'b0;
        less    <= 1'b0;
        cnt     <= bvg_pkg::TCNT_W'(bvg_pkg::TIME_BITS - 1);
        busy    <= 1'b1;
      end else if (busy) begin
        now_sr  <= now_sr >> 1;
        last_sr <= last_sr >> 1;
        ivl_sr  <= ivl_sr >> 1;
        borrow  <= borrow_next;
        less    <= less_next;
        cnt     <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/core/bvg_mult.sv =====
// ----------------------------------------------------------------------------
// bvg_mult
// Shift-add multiplier: pin millivolts times divider ratio, one ratio bit a cycle.
// ----------------------------------------------------------------------------
module bvg_mult (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bvg_pkg::ADC_BITS-1:0]  pin_mv,
  input  logic [bvg_pkg::RATIO_W-1:0]   ratio,
  output bvg_pkg::unit_stat_t           stat,
  output logic [bvg_pkg::PROD_W-1:0]    product
);

  logic [bvg_pkg::PROD_W-1:0]  mcand;
  logic [bvg_pkg::RATIO_W-1:0] mplier;
  logic [bvg_pkg::MCNT_W-1:0]  cnt;
  logic                        busy;
  logic                        done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mcand   <= bvg_pkg::PROD_W'(pin_mv);
        mplier  <= ratio;
        product <= '0;
        cnt     <= bvg_pkg::MCNT_W'(bvg_pkg::RATIO_W - 1);
        busy    <= 1'b1;
      end else if (busy) begin
        if (mplier[0]) begin
          product <= product + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/core/bvg_div.sv =====
// ----------------------------------------------------------------------------
// bvg_div
// Restoring divider, one quotient bit a cycle, MSB first. Shared by the /10
// scaling and the percent computation.
// ----------------------------------------------------------------------------
module bvg_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bvg_pkg::DIV_NW-1:0]   numer,
  input  logic [bvg_pkg::MV_W-1:0]     denom,
  output bvg_pkg::unit_stat_t          stat,
  output logic [bvg_pkg::DIV_NW-1:0]   quot
);

  logic [bvg_pkg::MV_W-1:0]   rem;
  logic [bvg_pkg::MV_W-1:0]   den;
  logic [bvg_pkg::DCNT_W-1:0] cnt;
  logic                       busy;
  logic                       done;
  logic [bvg_pkg::MV_W:0]     shifted;
  logic [bvg_pkg::MV_W+1:0]   diff;
  logic                       ge;

  // quot starts out holding the numerator; bits shift out the top as
  // quotient bits shift in at the bottom
  assign shifted = {rem, quot[bvg_pkg::DIV_NW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den};
  assign ge      = ~diff[bvg_pkg::MV_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= numer;
        den  <= denom;
        rem  <= '0;
        cnt  <= bvg_pkg::DCNT_W'(bvg_pkg::DIV_NW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? diff[bvg_pkg::MV_W-1:0] : shifted[bvg_pkg::MV_W-1:0];
        quot <= {quot[bvg_pkg::DIV_NW-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/core/battery_voltage_gauge.sv =====
// ----------------------------------------------------------------------------
// battery_voltage_gauge
// Smoothed battery voltage, charge percent and low flag from timer ticks.
// ----------------------------------------------------------------------------
// Flow: a skipped sample runs the serial time check, then picks its percent;
//   a sampled one adds the /10 divide and judge step; either adds a percent
//   divide when the average is valid and lies strictly between empty and full.
// Ticks are taken one at a time, the next the cycle after the result
//   is registered; the time per tick is set by the serial time check, the
//   shared bit-serial divider and any wait for room in the output register.
// Reset: rst (sync, high) loads register defaults and clears average state.
// ----------------------------------------------------------------------------
module battery_voltage_gauge (
  input  logic                            clk,
  input  logic                            rst,

  // tick input: now_ms [TIME_BITS-1:0], pin_mv [next ADC_BITS], zero fill
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bvg_pkg::S_TDATA_W-1:0]   s_tdata,

  // result: sampled [0], battery_valid [1], smoothed_mv [17:2],
  //   percent [25:18], battery_low [26], zero fill
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bvg_pkg::M_TDATA_W-1:0]   m_tdata,

  // register write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bvg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bvg_pkg::MV_W-1:0]        cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIME,     // serial interval check, multiply runs alongside
    ST_SCALE,    // product / 10
    ST_JUDGE,    // plausibility window and average update
    ST_PCT,      // pick percent or start its divide
    ST_PCTDIV,
    ST_OUT       // wait for room in the output register
  } state_t;

  state_t state;

  // configuration
  logic [bvg_pkg::RATIO_W-1:0] divider_ratio_x10;
  logic [bvg_pkg::MV_W-1:0]    plausible_min_mv;
  logic [bvg_pkg::MV_W-1:0]    plausible_max_mv;
  logic [bvg_pkg::MV_W-1:0]    full_mv;
  logic [bvg_pkg::MV_W-1:0]    empty_mv;
  logic [bvg_pkg::MV_W-1:0]    low_mv;
  logic [bvg_pkg::MV_W-1:0]    sample_interval_ms;

  // gauge state
  logic                          valid_flag;
  logic [bvg_pkg::MV_W-1:0]      average_mv;
  logic [bvg_pkg::TIME_BITS-1:0] last_sample_time;
  logic                          average_started;

  // per-tick working registers
  logic [bvg_pkg::TIME_BITS-1:0] now_ms;
  logic [bvg_pkg::ADC_BITS-1:0]  pin_mv;
  logic                          sampled;
  logic [bvg_pkg::PCT_W-1:0]     percent;
  logic                          unit_start;
  logic                          div_start;
  logic [bvg_pkg::DIV_NW-1:0]    div_numer;
  logic [bvg_pkg::MV_W-1:0]      div_denom;

  bvg_pkg::unit_stat_t          tcmp_stat;
  bvg_pkg::unit_stat_t          mult_stat;
  bvg_pkg::unit_stat_t          div_stat;
  logic                         too_soon;
  logic [bvg_pkg::PROD_W-1:0]   product;
  logic [bvg_pkg::DIV_NW-1:0]   quot;

  logic [bvg_pkg::PROD_W-1:0]    vbat;
  logic                          plausible;
  logic [bvg_pkg::MV_W+1:0]      blend_sum;
  logic [bvg_pkg::PCT_NUM_W-1:0] pct_numer;
  logic                          is_low;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  bvg_tcmp u_tcmp (
    .clk         (clk),
    .rst         (rst),
    .start       (unit_start),
    .now_ms      (now_ms),
    .last_ms     (last_sample_time),
    .interval_ms (sample_interval_ms),
    .stat        (tcmp_stat),
    .less        (too_soon)
  );

  bvg_mult u_mult (
    .clk     (clk),
    .rst     (rst),
    .start   (unit_start),
    .pin_mv  (pin_mv),
    .ratio   (divider_ratio_x10),
    .stat    (mult_stat),
    .product (product)
  );

  bvg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .stat  (div_stat),
    .quot  (quot)
  );

  // scaled reading; a quotient of a PROD_W-bit numerator fits PROD_W bits
  assign vbat      = quot[bvg_pkg::PROD_W-1:0];
  assign plausible = (vbat >= bvg_pkg::PROD_W'(plausible_min_mv)) &&
                     (vbat <= bvg_pkg::PROD_W'(plausible_max_mv));
  // 3:1 blend; a plausible reading never exceeds 16 bits
  assign blend_sum = {2'b00, average_mv} + {1'b0, average_mv, 1'b0} +
                     {2'b00, vbat[bvg_pkg::MV_W-1:0]};
  assign pct_numer = bvg_pkg::PCT_NUM_W'(average_mv - empty_mv) * bvg_pkg::PCT_SCALE;
  assign is_low    = valid_flag && (average_mv < low_mv);

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      divider_ratio_x10  <= bvg_pkg::RST_DIVIDER;
      plausible_min_mv   <= bvg_pkg::RST_PL_MIN;
      plausible_max_mv   <= bvg_pkg::RST_PL_MAX;
      full_mv            <= bvg_pkg::RST_FULL;
      empty_mv           <= bvg_pkg::RST_EMPTY;
      low_mv             <= bvg_pkg::RST_LOW;
      sample_interval_ms <= bvg_pkg::RST_INTERVAL;
      valid_flag         <= 1'b0;
      average_mv         <= '0;
      last_sample_time   <= '0;
      average_started    <= 1'b0;
      unit_start         <= 1'b0;
      div_start          <= 1'b0;
      m_tvalid           <= 1'b0;
    end else begin
      unit_start <= 1'b0;
      div_start  <= 1'b0;

      if (cfg_valid) begin
        case (bvg_pkg::cfg_reg_t'(cfg_index))
          bvg_pkg::REG_DIVIDER:  divider_ratio_x10  <= cfg_data[bvg_pkg::RATIO_W-1:0];
          bvg_pkg::REG_PL_MIN:   plausible_min_mv   <= cfg_data;
          bvg_pkg::REG_PL_MAX:   plausible_max_mv   <= cfg_data;
          bvg_pkg::REG_FULL:     full_mv            <= cfg_data;
          bvg_pkg::REG_EMPTY:    empty_mv           <= cfg_data;
          bvg_pkg::REG_LOW:      low_mv             <= cfg_data;
          bvg_pkg::REG_INTERVAL: sample_interval_ms <= cfg_data;
          default: ;
        endcase
      end

      // output register: loaded in ST_OUT when free, dropped once taken
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            now_ms     <= s_tdata[bvg_pkg::TIME_BITS-1:0];
            pin_mv     <= s_tdata[bvg_pkg::IN_W-1:bvg_pkg::TIME_BITS];
            unit_start <= 1'b1;
            state      <= ST_TIME;
          end
        end

        ST_TIME: begin
          // multiply is shorter than the time check; busy test is a guard
          if (tcmp_stat.done && !mult_stat.busy) begin
            if (average_started && too_soon) begin
              sampled <= 1'b0;
              state   <= ST_PCT;
            end else begin
              sampled   <= 1'b1;
              div_numer <= bvg_pkg::DIV_NW'(product);
              div_denom <= bvg_pkg::SCALE_DIVISOR;
              div_start <= 1'b1;
              state     <= ST_SCALE;
            end
          end
        end

        ST_SCALE: begin
          if (div_stat.done) begin
            state <= ST_JUDGE;
          end
        end

        ST_JUDGE: begin
          last_sample_time <= now_ms;
          if (!plausible) begin
            valid_flag <= 1'b0;
          end else begin
            if (!average_started) begin
              average_mv      <= vbat[bvg_pkg::MV_W-1:0];
              average_started <= 1'b1;
            end else begin
              average_mv <= blend_sum[bvg_pkg::MV_W+1:2];
            end
            valid_flag <= 1'b1;
          end
          state <= ST_PCT;
        end

        ST_PCT: begin
          // full not above empty falls into one of the clamps, never divides
          if (!valid_flag) begin
            percent <= bvg_pkg::PCT_UNKNOWN;
            state   <= ST_OUT;
          end else if (average_mv >= full_mv) begin
            percent <= bvg_pkg::PCT_FULL;
            state   <= ST_OUT;
          end else if (average_mv <= empty_mv) begin
            percent <= bvg_pkg::PCT_EMPTY;
            state   <= ST_OUT;
          end else begin
            div_numer <= bvg_pkg::DIV_NW'(pct_numer);
            div_denom <= full_mv - empty_mv;
            div_start <= 1'b1;
            state     <= ST_PCTDIV;
          end
        end

        ST_PCTDIV: begin
          if (div_stat.done) begin
            percent <= quot[bvg_pkg::PCT_W-1:0];
            state   <= ST_OUT;
          end
        end

        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= bvg_pkg::M_TDATA_W'({is_low, percent, average_mv,
                                             valid_flag, sampled});
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
